FILE: hdl/menv_pkg.sv
// Shared types, codes and the envelope compare for the message envelope matcher.
// No dependencies.
package menv_pkg;

    localparam int REQ_DEPTH_DEF = 16;
    localparam int HDR_DEPTH_DEF = 16;

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] epoch;
        logic [15:0] context_req;
        logic [15:0] source;
        logic [14:0] destination;
        logic [15:0] tag;
    } t_env;

    typedef enum logic [1:0] {
        F_POST_REQ = 2'd0,
        F_POST_HDR = 2'd1,
        F_PROGRESS = 2'd2,
        F_UNUSED   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        K_ACCEPTED = 3'd0,
        K_NOMATCH  = 3'd1,
        K_MATCHED  = 3'd2,
        K_FLUSHED  = 3'd3,
        K_STALE    = 3'd4,
        K_FULL     = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_EPOCH    = 2'd0,
        CFG_CLEANUP  = 2'd1,
        CFG_ANY_SRC  = 2'd2,
        CFG_ANY_TAG  = 2'd3
    } t_cfg_idx;

    // Wildcards apply only on the request side; signed fields compare as raw bits.
    function automatic logic env_match(input t_env req, input t_env hdr,
                                       input logic [15:0] any_src,
                                       input logic [15:0] any_tag);
        logic ok;
        ok = (req.epoch == hdr.epoch) && (req.context_req == hdr.context_req) &&
             (req.destination == hdr.destination) &&
             ((req.source == any_src) || (req.source == hdr.source)) &&
             ((req.tag == any_tag) || (req.tag == hdr.tag));
        return ok;
    endfunction

endpackage

FILE: hdl/menv_cell.sv
// One queue slot: holds an envelope, loads a new one or takes its neighbor's.
// Depends on menv_pkg.
module menv_cell
    import menv_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_shift,
    input  t_env i_new,
    input  t_env i_next,
    output t_env o_ent
);

    t_env r_ent;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ent <= i_next;
        end else if (i_load) begin
            r_ent <= i_new;
        end
    end

    assign o_ent = r_ent;

endmodule

FILE: hdl/menv_queue.sv
// Ordered queue built as a row of menv_cell slots, oldest in slot 0.
// Removal at any slot closes the gap by shifting the younger slots down.
// Depends on menv_pkg and menv_cell.
module menv_queue
    import menv_pkg::*;
#(
    parameter int DEPTH = REQ_DEPTH_DEF,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_env          i_new,
    input  logic          i_pop,
    input  logic [IW-1:0] i_pop_idx,
    output t_env          o_ent [DEPTH],
    output logic [CW-1:0] o_count
);

    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= r_count + 1'b1;
        end else if (i_pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_env w_next;
        if (k < DEPTH - 1) begin : g_mid
            assign w_next = o_ent[k+1];
        end else begin : g_end
            assign w_next = o_ent[k];
        end
        menv_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (i_push && (r_count == CW'(k))),
            .i_shift (i_pop && (IW'(k) >= i_pop_idx)),
            .i_new   (i_new),
            .i_next  (w_next),
            .o_ent   (o_ent[k])
        );
    end

    assign o_count = r_count;

endmodule

FILE: hdl/message_envelope_matcher.sv
// Message envelope matcher: posted requests matched against arrived headers.
// Input stream: s_tuser = func; s_tdata = handle, epoch, context, source,
// destination, tag. Output stream: m_tuser = kind; m_tdata = request handle,
// header handle; m_tlast marks the final result of an input request.
// Configuration by a plain write port (epoch, cleanup tag, wildcard codes).
// Posting a request or an unused code: result in the output register at the
// accept edge. Posting a header: the result comes from the header state; a
// cleanup tag first flushes every posted request (each flushed request gives
// one result) and then leaves the flush. Progress: requests are scanned in
// turn, oldest first (compare the request against every header slot at once,
// then pick the oldest hit), with a no-match result when no request matches.
// One input request is worked at a time; s_tready is high only when idle and
// the output register is free or being drained.
// Reset empties both queues, restores register defaults and drops any
// pending result. When the receiver stalls, the result holds in the output
// register and the block waits before producing the next one.
// Depends on menv_pkg and menv_queue.
module message_envelope_matcher
    import menv_pkg::*;
#(
    parameter int REQ_DEPTH = REQ_DEPTH_DEF,
    parameter int HDR_DEPTH = HDR_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // handle, epoch, context_req, source, destination, tag, pad
    input  logic [1:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // request_handle, header_handle
    output logic [2:0]  m_tuser,  // kind
    output logic        m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int RCW = $clog2(REQ_DEPTH + 1);
    localparam int RIW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int HCW = $clog2(HDR_DEPTH + 1);
    localparam int HIW = (HDR_DEPTH > 1) ? $clog2(HDR_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_FLUSH, S_HDR, S_SCAN, S_EVAL} t_state;

    t_state         r_state;
    logic [15:0]    r_cur_epoch, r_cleanup, r_any_src, r_any_tag;
    t_env           r_item;
    logic [RCW-1:0] r_idx;
    logic [HDR_DEPTH-1:0] r_hit;
    logic           r_ovalid, r_olast;
    t_kind          r_okind;
    logic [7:0]     r_orh, r_ohh;

    t_env           w_in;
    t_func          w_func;
    t_env           req_ent [REQ_DEPTH];
    t_env           hdr_ent [HDR_DEPTH];
    logic [RCW-1:0] req_count;
    logic [HCW-1:0] hdr_count;
    logic           can_emit, acc, req_full, hdr_full, stale;
    logic           out_load;
    logic           req_push, req_pop, hdr_push, hdr_pop;
    logic [RIW-1:0] req_pop_idx;
    logic [HIW-1:0] hfirst;
    t_env           req_sel;
    logic [HDR_DEPTH-1:0] hit;

    // handle sits in the lowest bits of s_tdata
    assign w_in = {s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], s_tdata[55:40],
                   s_tdata[70:56], s_tdata[86:71]};
    assign w_func = t_func'(s_tuser);

    assign can_emit = !r_ovalid || m_tready;
    assign s_tready = (r_state == S_IDLE) && can_emit;
    assign acc      = s_tvalid && s_tready;
    assign req_full = (req_count >= RCW'(REQ_DEPTH));
    assign hdr_full = (hdr_count >= HCW'(HDR_DEPTH));
    assign stale    = (r_item.epoch < r_cur_epoch);
    assign req_sel  = req_ent[r_idx[RIW-1:0]];

    for (genvar h = 0; h < HDR_DEPTH; h++) begin : g_hit
        assign hit[h] = (HCW'(h) < hdr_count) &&
                        env_match(req_sel, hdr_ent[h], r_any_src, r_any_tag);
    end

    always_comb begin
        hfirst = '0;
        for (int h = HDR_DEPTH - 1; h >= 0; h--) begin
            if (r_hit[h]) hfirst = HIW'(h);
        end
    end

    // a new result enters the output register this cycle
    always_comb begin
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  out_load = acc && (w_func != F_POST_HDR) && (w_func != F_PROGRESS);
            S_FLUSH: out_load = can_emit && (req_count != '0);
            S_HDR:   out_load = can_emit;
            S_SCAN:  out_load = can_emit && (r_idx >= req_count);
            S_EVAL:  out_load = can_emit && (|r_hit);
            default: out_load = 1'b0;
        endcase
    end

    always_comb begin
        req_push    = acc && (w_func == F_POST_REQ) && !req_full;
        hdr_push    = (r_state == S_HDR) && can_emit && !stale && !hdr_full;
        req_pop     = ((r_state == S_FLUSH) && can_emit && (req_count != '0)) ||
                      ((r_state == S_EVAL) && can_emit && (|r_hit));
        hdr_pop     = (r_state == S_EVAL) && can_emit && (|r_hit);
        req_pop_idx = (r_state == S_FLUSH) ? '0 : r_idx[RIW-1:0];
    end

    menv_queue #(.DEPTH(REQ_DEPTH)) u_req (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (req_push),
        .i_new     (w_in),
        .i_pop     (req_pop),
        .i_pop_idx (req_pop_idx),
        .o_ent     (req_ent),
        .o_count   (req_count)
    );

    menv_queue #(.DEPTH(HDR_DEPTH)) u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (hdr_push),
        .i_new     (r_item),
        .i_pop     (hdr_pop),
        .i_pop_idx (hfirst),
        .o_ent     (hdr_ent),
        .o_count   (hdr_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_cur_epoch <= 16'h0000;
            r_cleanup   <= 16'h8000;
            r_any_src   <= 16'hFFFF;
            r_any_tag   <= 16'hFFFE;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_EPOCH:   r_cur_epoch <= i_cfg_data;
                    CFG_CLEANUP: r_cleanup   <= i_cfg_data;
                    CFG_ANY_SRC: r_any_src   <= i_cfg_data;
                    CFG_ANY_TAG: r_any_tag   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_ovalid <= out_load || (r_ovalid && !m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_item <= w_in;
                        r_idx  <= '0;
                        case (w_func)
                            F_POST_REQ: begin
                                r_okind  <= req_full ? K_FULL : K_ACCEPTED;
                                r_orh    <= '0;
                                r_ohh    <= '0;
                                r_olast  <= 1'b1;
                            end
                            F_POST_HDR: begin
                                r_state <= (w_in.tag == r_cleanup) ? S_FLUSH : S_HDR;
                            end
                            F_PROGRESS: r_state <= S_SCAN;
                            default: begin
                                r_okind  <= K_ACCEPTED;
                                r_orh    <= '0;
                                r_ohh    <= '0;
                                r_olast  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FLUSH: begin
                    if (req_count == '0) begin
                        r_state <= S_HDR;
                    end else if (can_emit) begin
                        r_okind  <= K_FLUSHED;
                        r_orh    <= req_ent[0].handle;
                        r_ohh    <= '0;
                        r_olast  <= 1'b0;
                    end
                end
                S_HDR: begin
                    if (can_emit) begin
                        r_okind  <= stale ? K_STALE : (hdr_full ? K_FULL : K_ACCEPTED);
                        r_orh    <= '0;
                        r_ohh    <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (r_idx >= req_count) begin
                        if (can_emit) begin
                            r_okind  <= K_NOMATCH;
                            r_orh    <= '0;
                            r_ohh    <= '0;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_hit   <= hit;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (|r_hit) begin
                        if (can_emit) begin
                            r_okind  <= K_MATCHED;
                            r_orh    <= req_sel.handle;
                            r_ohh    <= hdr_ent[hfirst].handle;
                            r_olast  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {r_ohh, r_orh};
    assign m_tuser  = r_okind;
    assign m_tlast  = r_olast;

endmodule

FILE: hdl/menv_checker.sv
// Port-level checks for message_envelope_matcher, bound to the top level.
// Depends on menv_pkg.
module menv_checker
    import menv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Only flushed requests are followed by another result of the same request.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != K_FLUSHED)))
        else $error("tlast does not follow result kind");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while output register blocked");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind message_envelope_matcher menv_checker u_menv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
